>>> hw/rtl/register_vm_alu_executor_defines.svh
// Assertion macros shared by the RTL of the register VM ALU executor.
// Clocked forms with and without a reset qualifier; empty when SYNTHESIS is set.
`ifndef REGISTER_VM_ALU_EXECUTOR_DEFINES_SVH
`define REGISTER_VM_ALU_EXECUTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define RVM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RVM_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVM_ASSERT(lbl, clk, rst_n, prop, msg)
`define RVM_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/rvm_alu_pkg.sv
package rvm_alu_pkg;

    localparam int DATA_W       = 32;
    localparam int REG_IDX_W    = 5;
    localparam int NUM_REGS_DEF = 32;
    localparam int CNT_W        = $clog2(DATA_W);

    typedef enum logic [2:0] {
        KIND_MOVE   = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_SUB    = 3'd2,
        KIND_MUL    = 3'd3,
        KIND_DIV    = 3'd4,
        KIND_MOD    = 3'd5,
        KIND_RETURN = 3'd6,
        KIND_NOP    = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_NO_RET   = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/register_vm_alu_executor.sv
// Register VM ALU executor: runs one decoded instruction per input beat
// against a file of NUM_REGS signed 32-bit registers.
// Input channel: i_in_valid / o_in_stall carry kind, dest_reg, src_a, src_b,
// value and last. A beat is taken on an edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry returned, ret_value and
// error; exactly one result beat leaves for every input beat.
// Move, add, sub, return and no-op go straight from execute to write-back;
// multiply takes 32 shift-add passes, divide and modulo take 32 restoring
// passes plus a sign fix-up, and a division by zero skips them. All
// arithmetic runs through one 32-bit adder/subtractor, and the register
// file is a single-port-read RAM read twice per instruction.
// o_in_stall is high while an instruction is in flight and drops in the
// same cycle as its result is raised, so the block takes no new beat until
// the last instruction has handed over its result.
// Reset clears the sequencer, the output valid flag and the per-entry valid
// bits, so every register reads as zero until written.
// A stalled result waits in the output register; the next instruction is
// still accepted and executed, and only its final write-back and result
// hand-over hold until the output register is free.
module register_vm_alu_executor #(
    parameter int NUM_REGS = rvm_alu_pkg::NUM_REGS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_kind,
    input  logic [rvm_alu_pkg::REG_IDX_W-1:0]   i_dest_reg,
    input  logic [rvm_alu_pkg::REG_IDX_W-1:0]   i_src_a,
    input  logic [rvm_alu_pkg::REG_IDX_W-1:0]   i_src_b,
    input  logic signed [rvm_alu_pkg::DATA_W-1:0] i_value,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_returned,
    output logic signed [rvm_alu_pkg::DATA_W-1:0] o_ret_value,
    output logic [1:0]                          o_error
);

`include "register_vm_alu_executor_defines.svh"

    localparam int DW     = rvm_alu_pkg::DATA_W;
    localparam int IW     = rvm_alu_pkg::REG_IDX_W;
    localparam int CW     = rvm_alu_pkg::CNT_W;
    localparam int ADDR_W = $clog2(NUM_REGS);
    localparam int EXT_W  = (ADDR_W > IW) ? ADDR_W : IW;
    localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

    // control state
    rvm_alu_pkg::t_state r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [NUM_REGS-1:0] r_vld, n_vld;

    // instruction and datapath registers
    rvm_alu_pkg::t_kind  r_kind, n_kind;
    logic [IW-1:0]       r_dst, n_dst;
    logic [IW-1:0]       r_sa, n_sa;
    logic [IW-1:0]       r_sb, n_sb;
    logic [DW-1:0]       r_val, n_val;
    logic                r_last, n_last;
    logic [DW-1:0]       r_a, n_a;      // left operand, multiplicand, quotient
    logic [DW-1:0]       r_b, n_b;      // multiplier, divisor magnitude
    logic [DW-1:0]       r_res, n_res;  // result, product sum, remainder
    logic                r_ret, n_ret;
    logic                r_wr, n_wr;
    logic                r_div0, n_div0;
    logic                r_neg_q, n_neg_q;
    logic                r_neg_r, n_neg_r;
    logic                r_rd_ok;

    // output register payload
    logic                    r_returned, n_returned;
    logic [DW-1:0]           r_ret_value, n_ret_value;
    rvm_alu_pkg::t_err       r_error, n_error;

    // shared adder/subtractor
    logic [DW-1:0] w_add_x, w_add_y;
    logic          w_add_sub;
    logic [DW:0]   w_sum;

    // register file access
    logic [IW-1:0]     w_rd_idx;
    logic [EXT_W-1:0]  w_rd_ext, w_wr_ext;
    logic [ADDR_W-1:0] w_rd_addr, w_wr_addr;
    logic              w_rd_ok, w_dst_ok;
    logic [DW-1:0]     w_rdata, w_opnd;
    logic              w_we;

    logic [DW-1:0]     w_mag_a, w_mag_b, w_div_x;
    logic              w_slot_free;

    rvm_alu_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_addr),
        .i_wdata (r_res),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    // One adder serves add, subtract, every multiply and divide pass, and
    // the sign fix-up: x + (y or ~y) + sub.
    assign w_sum = {1'b0, w_add_x} + {1'b0, w_add_y ^ {DW{w_add_sub}}} + (DW + 1)'(w_add_sub);

    // Return reads its destination; otherwise read src_a, then src_b.
    assign w_rd_idx  = (r_state == rvm_alu_pkg::S_RDB) ? r_sb :
                       ((r_kind == rvm_alu_pkg::KIND_RETURN) ? r_dst : r_sa);
    assign w_rd_ext  = EXT_W'(w_rd_idx);
    assign w_rd_addr = w_rd_ext[ADDR_W-1:0];
    assign w_wr_ext  = EXT_W'(r_dst);
    assign w_wr_addr = w_wr_ext[ADDR_W-1:0];

    // Out-of-range indices read as zero and drop writes; entries never
    // written since reset read as zero.
    assign w_rd_ok  = ({{(32 - IW){1'b0}}, w_rd_idx} < 32'(NUM_REGS)) && r_vld[w_rd_addr];
    assign w_dst_ok = ({{(32 - IW){1'b0}}, r_dst} < 32'(NUM_REGS));
    assign w_opnd   = r_rd_ok ? w_rdata : '0;

    assign w_mag_a  = r_a[DW-1] ? (~r_a + DW'(1)) : r_a;
    assign w_mag_b  = w_opnd[DW-1] ? (~w_opnd + DW'(1)) : w_opnd;
    assign w_div_x  = {r_res[DW-2:0], r_a[DW-1]};

    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_vld       = r_vld;
        n_kind      = r_kind;
        n_dst       = r_dst;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_val       = r_val;
        n_last      = r_last;
        n_a         = r_a;
        n_b         = r_b;
        n_res       = r_res;
        n_ret       = r_ret;
        n_wr        = r_wr;
        n_div0      = r_div0;
        n_neg_q     = r_neg_q;
        n_neg_r     = r_neg_r;
        n_returned  = r_returned;
        n_ret_value = r_ret_value;
        n_error     = r_error;
        w_add_x     = r_a;
        w_add_y     = w_opnd;
        w_add_sub   = 1'b0;
        w_we        = 1'b0;

        unique case (r_state)
            rvm_alu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = rvm_alu_pkg::t_kind'(i_kind);
                    n_dst   = i_dest_reg;
                    n_sa    = i_src_a;
                    n_sb    = i_src_b;
                    n_val   = i_value;
                    n_last  = i_last;
                    n_ret   = 1'b0;
                    n_wr    = 1'b0;
                    n_div0  = 1'b0;
                    n_state = rvm_alu_pkg::S_RDA;
                end
            end
            rvm_alu_pkg::S_RDA: begin
                n_state = rvm_alu_pkg::S_RDB;
            end
            rvm_alu_pkg::S_RDB: begin
                n_a     = w_opnd;
                n_state = rvm_alu_pkg::S_EXEC;
            end
            rvm_alu_pkg::S_EXEC: begin
                n_cnt   = '0;
                n_state = rvm_alu_pkg::S_DONE;
                unique case (r_kind) inside
                    rvm_alu_pkg::KIND_MOVE: begin
                        n_res = r_val;
                        n_wr  = 1'b1;
                    end
                    rvm_alu_pkg::KIND_ADD, rvm_alu_pkg::KIND_SUB: begin
                        w_add_x   = r_a;
                        w_add_y   = w_opnd;
                        w_add_sub = (r_kind == rvm_alu_pkg::KIND_SUB);
                        n_res     = w_sum[DW-1:0];
                        n_wr      = 1'b1;
                    end
                    rvm_alu_pkg::KIND_MUL: begin
                        n_res   = '0;
                        n_b     = w_opnd;
                        n_state = rvm_alu_pkg::S_MUL;
                    end
                    rvm_alu_pkg::KIND_DIV, rvm_alu_pkg::KIND_MOD: begin
                        if (w_opnd == '0) begin
                            n_div0 = 1'b1;
                        end else begin
                            n_res   = '0;
                            n_a     = w_mag_a;
                            n_b     = w_mag_b;
                            n_neg_q = r_a[DW-1] ^ w_opnd[DW-1];
                            n_neg_r = r_a[DW-1];
                            n_state = rvm_alu_pkg::S_DIV;
                        end
                    end
                    rvm_alu_pkg::KIND_RETURN: begin
                        n_ret = 1'b1;
                        n_res = r_a;
                    end
                    rvm_alu_pkg::KIND_NOP: begin
                        n_res = r_res;
                    end
                endcase
            end
            rvm_alu_pkg::S_MUL: begin
                // add the shifted multiplicand where the multiplier bit is set
                w_add_x = r_res;
                w_add_y = r_b[0] ? r_a : '0;
                n_res   = w_sum[DW-1:0];
                n_a     = {r_a[DW-2:0], 1'b0};
                n_b     = {1'b0, r_b[DW-1:1]};
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_wr    = 1'b1;
                    n_state = rvm_alu_pkg::S_DONE;
                end
            end
            rvm_alu_pkg::S_DIV: begin
                // restoring step: keep the difference when it does not borrow
                w_add_x   = w_div_x;
                w_add_y   = r_b;
                w_add_sub = 1'b1;
                n_res     = w_sum[DW] ? w_sum[DW-1:0] : w_div_x;
                n_a       = {r_a[DW-2:0], w_sum[DW]};
                n_cnt     = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = rvm_alu_pkg::S_FIX;
                end
            end
            rvm_alu_pkg::S_FIX: begin
                w_add_x = '0;
                if (r_kind == rvm_alu_pkg::KIND_DIV) begin
                    w_add_y   = r_a;
                    w_add_sub = r_neg_q;
                end else begin
                    w_add_y   = r_res;
                    w_add_sub = r_neg_r;
                end
                n_res   = w_sum[DW-1:0];
                n_wr    = 1'b1;
                n_state = rvm_alu_pkg::S_DONE;
            end
            rvm_alu_pkg::S_DONE: begin
                if (w_slot_free) begin
                    w_we        = r_wr && w_dst_ok;
                    if (w_we) begin
                        n_vld[w_wr_addr] = 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_returned  = r_ret;
                    n_ret_value = r_ret ? r_res : '0;
                    if (r_div0) begin
                        n_error = rvm_alu_pkg::ERR_DIV_ZERO;
                    end else if (r_last && !r_ret) begin
                        n_error = rvm_alu_pkg::ERR_NO_RET;
                    end else begin
                        n_error = rvm_alu_pkg::ERR_NONE;
                    end
                    n_state     = rvm_alu_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rvm_alu_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_vld       <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_dst       <= n_dst;
        r_sa        <= n_sa;
        r_sb        <= n_sb;
        r_val       <= n_val;
        r_last      <= n_last;
        r_a         <= n_a;
        r_b         <= n_b;
        r_res       <= n_res;
        r_ret       <= n_ret;
        r_wr        <= n_wr;
        r_div0      <= n_div0;
        r_neg_q     <= n_neg_q;
        r_neg_r     <= n_neg_r;
        r_rd_ok     <= w_rd_ok;
        r_returned  <= n_returned;
        r_ret_value <= n_ret_value;
        r_error     <= n_error;
    end

    // Hold off new beats while an instruction is in flight.
    assign o_in_stall  = (r_state != rvm_alu_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_returned  = r_returned;
    assign o_ret_value = r_ret_value;
    assign o_error     = r_error;

    `RVM_ASSERT(a_accept_starts_read, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> (r_state == rvm_alu_pkg::S_RDA), "accepted beat did not start a register read")
    `RVM_ASSERT(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == rvm_alu_pkg::S_DONE), "result beat raised outside write-back")
    `RVM_ASSERT(a_write_in_done, i_clk, i_rst_n, w_we |-> ((r_state == rvm_alu_pkg::S_DONE) && w_slot_free), "register write outside write-back")
    `RVM_ASSERT(a_ret_value_zero, i_clk, i_rst_n, (r_out_valid && !r_returned) |-> (r_ret_value == '0), "non-return result carries a value")
    `RVM_ASSERT(a_return_no_error, i_clk, i_rst_n, (r_out_valid && r_returned) |-> (r_error == rvm_alu_pkg::ERR_NONE), "return result flagged an error")

endmodule

>>> hw/rtl/rvm_alu_ram.sv
module rvm_alu_ram #(
    parameter int WIDTH = rvm_alu_pkg::DATA_W,
    parameter int DEPTH = rvm_alu_pkg::NUM_REGS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
